>>> rtl/core/sws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sws_pkg - shared types and constants for the sorting stack
// Beat layouts, operation and status codes, and derived sizes of the store.
// ----------------------------------------------------------------------------
package sws_pkg;

  // Store size and the widths that follow from it
  localparam int STACK_DEPTH   = 128;
  localparam int CNT_W         = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W        = $clog2(STACK_DEPTH);
  localparam int WORD_W        = 32;
  localparam int COUNT_FIELD_W = 8;

  typedef logic [1:0] kind_t;
  typedef logic [1:0] status_t;

  // Operation codes
  localparam kind_t KIND_PUSH   = 2'd0;
  localparam kind_t KIND_POP    = 2'd1;
  localparam kind_t KIND_REMOVE = 2'd2;
  localparam kind_t KIND_SORT   = 2'd3;

  // Status codes
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;

  localparam logic signed [WORD_W-1:0] MINUS_ONE = {WORD_W{1'b1}};

  typedef struct packed {
    kind_t                    kind;
    logic signed [WORD_W-1:0] value;
  } req_t;

  typedef struct packed {
    status_t                  status;
    logic signed [WORD_W-1:0] popped_value;
    logic signed [WORD_W-1:0] top_value;
    logic [COUNT_FIELD_W-1:0] entry_count;
  } rsp_t;

endpackage

>>> rtl/core/sws_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sws_ram - simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module sws_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/stack_with_remove_and_sort.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_with_remove_and_sort - bounded stack with remove-all and sort
// Push, pop, remove every copy of a word, and sort ascending (smallest on
// top) over a RAM-backed stack and a RAM-backed scratch stack.
// ----------------------------------------------------------------------------
// One request beat is taken at a time and gives one response beat. A push,
// or a pop on an empty stack, goes straight to loading the response; any
// other pop first reads the new top, and a remove-all reads and checks each
// of the n held entries in turn. A sort pops each entry and inserts it into
// the scratch stack, moving larger scratch entries back (at most n(n-1)/2),
// and each moved entry is popped and inserted again; the scratch stack is
// then poured back. The next request is taken once the sequencer is back in
// idle. Each store has a single read port whose data is registered, and the
// sort shares one signed comparator across all its steps. The block holds
// req_stall high from acceptance until the response is loaded, and a
// response waiting in the output register does not block a new request.
module stack_with_remove_and_sort
  import sws_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  // Sequencer states
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_POP_LD   = 4'd1;
  localparam logic [3:0] S_RM_RD    = 4'd2;
  localparam logic [3:0] S_RM_CHK   = 4'd3;
  localparam logic [3:0] S_SRT_POP  = 4'd4;
  localparam logic [3:0] S_SRT_LOAD = 4'd5;
  localparam logic [3:0] S_SRT_CMP  = 4'd6;
  localparam logic [3:0] S_SRT_ATOP = 4'd7;
  localparam logic [3:0] S_POUR     = 4'd8;
  localparam logic [3:0] S_POUR_LD  = 4'd9;
  localparam logic [3:0] S_DONE     = 4'd10;

  logic [3:0]               state;
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         ap;
  logic [CNT_W-1:0]         idx;
  logic signed [WORD_W-1:0] top;
  logic signed [WORD_W-1:0] cur;
  logic signed [WORD_W-1:0] atop;
  logic signed [WORD_W-1:0] val;
  logic signed [WORD_W-1:0] popped;
  status_t                  status;

  logic                     req_fire;
  logic                     full;
  logic                     move;
  logic [CNT_W-1:0]         cnt_m1;
  logic [CNT_W-1:0]         cnt_m2;
  logic [CNT_W-1:0]         ap_m2;

  logic                     st_we;
  logic [ADDR_W-1:0]        st_waddr;
  logic [WORD_W-1:0]        st_wdata;
  logic [ADDR_W-1:0]        st_raddr;
  logic [WORD_W-1:0]        st_rdata;
  logic                     sc_we;
  logic [ADDR_W-1:0]        sc_waddr;
  logic [WORD_W-1:0]        sc_wdata;
  logic [ADDR_W-1:0]        sc_raddr;
  logic [WORD_W-1:0]        sc_rdata;

  assign req_stall = (state != S_IDLE);
  assign req_fire  = req_valid && !req_stall;
  assign full      = (count == CNT_W'(STACK_DEPTH));
  assign cnt_m1    = count - CNT_W'(1);
  assign cnt_m2    = count - CNT_W'(2);
  assign ap_m2     = ap - CNT_W'(2);

  // Shared comparator: scratch top larger than the word being inserted
  assign move = (ap != '0) && (atop > cur);

  // Drive the store ports from the sequencer state
  always_comb begin
    st_we    = 1'b0;
    st_waddr = count[ADDR_W-1:0];
    st_wdata = atop;
    st_raddr = cnt_m1[ADDR_W-1:0];
    sc_we    = 1'b0;
    sc_waddr = ap[ADDR_W-1:0];
    sc_wdata = cur;
    sc_raddr = ap_m2[ADDR_W-1:0];
    unique case (state)
      S_IDLE: begin
        st_raddr = cnt_m2[ADDR_W-1:0];
        if (req_fire && req.kind == KIND_PUSH && !full) begin
          st_we    = 1'b1;
          st_wdata = req.value;
        end
      end
      S_RM_RD: begin
        st_raddr = idx[ADDR_W-1:0];
      end
      S_RM_CHK: begin
        if ($signed(st_rdata) != val) begin
          st_we    = 1'b1;
          st_waddr = ap[ADDR_W-1:0];
          st_wdata = st_rdata;
        end
      end
      S_SRT_CMP: begin
        if (move) begin
          st_we = 1'b1;
        end else begin
          sc_we = 1'b1;
        end
      end
      S_POUR: begin
        st_we = (ap != '0);
      end
      default: begin
      end
    endcase
  end

  sws_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  sws_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STACK_DEPTH)
  ) u_scratch_ram (
    .clk   (clk),
    .we    (sc_we),
    .waddr (sc_waddr),
    .wdata (sc_wdata),
    .raddr (sc_raddr),
    .rdata (sc_rdata)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // drop the response beat once taken, unless a new one is loaded
      if (rsp_valid && !rsp_stall && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_fire) begin
            val <= req.value;
            idx <= '0;
            ap  <= '0;
            unique case (req.kind)
              KIND_PUSH: begin
                popped <= '0;
                if (full) begin
                  status <= ST_FULL;
                end else begin
                  status <= ST_OK;
                  count  <= count + CNT_W'(1);
                  top    <= req.value;
                end
                state <= S_DONE;
              end
              KIND_POP: begin
                if (count == '0) begin
                  status <= ST_EMPTY;
                  popped <= MINUS_ONE;
                  state  <= S_DONE;
                end else begin
                  status <= ST_OK;
                  popped <= top;
                  count  <= cnt_m1;
                  state  <= S_POP_LD;
                end
              end
              KIND_REMOVE: begin
                status <= ST_OK;
                popped <= '0;
                state  <= S_RM_RD;
              end
              default: begin
                status <= ST_OK;
                popped <= '0;
                state  <= S_SRT_POP;
              end
            endcase
          end
        end
        // pick up the entry now on top after a pop
        S_POP_LD: begin
          top   <= st_rdata;
          state <= S_DONE;
        end
        // compact in place from the bottom, ap is the write index
        S_RM_RD: begin
          if (idx == count) begin
            count <= ap;
            state <= S_DONE;
          end else begin
            idx   <= idx + CNT_W'(1);
            state <= S_RM_CHK;
          end
        end
        S_RM_CHK: begin
          if ($signed(st_rdata) != val) begin
            ap  <= ap + CNT_W'(1);
            top <= st_rdata;
          end
          state <= S_RM_RD;
        end
        // pop the next word off the stack for insertion
        S_SRT_POP: begin
          if (count == '0) begin
            state <= S_POUR;
          end else begin
            count <= cnt_m1;
            state <= S_SRT_LOAD;
          end
        end
        S_SRT_LOAD: begin
          cur   <= st_rdata;
          state <= S_SRT_CMP;
        end
        // move larger scratch entries back, else insert the word
        S_SRT_CMP: begin
          if (move) begin
            count <= count + CNT_W'(1);
            ap    <= ap - CNT_W'(1);
            state <= S_SRT_ATOP;
          end else begin
            ap    <= ap + CNT_W'(1);
            atop  <= cur;
            state <= S_SRT_POP;
          end
        end
        S_SRT_ATOP: begin
          atop  <= sc_rdata;
          state <= S_SRT_CMP;
        end
        // pour the scratch stack back, smallest lands on top
        S_POUR: begin
          if (ap == '0) begin
            state <= S_DONE;
          end else begin
            count <= count + CNT_W'(1);
            ap    <= ap - CNT_W'(1);
            top   <= atop;
            state <= S_POUR_LD;
          end
        end
        S_POUR_LD: begin
          atop  <= sc_rdata;
          state <= S_POUR;
        end
        // load the response beat once the output register is free
        S_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid        <= 1'b1;
            rsp.status       <= status;
            rsp.popped_value <= popped;
            rsp.top_value    <= (count == '0) ? MINUS_ONE : top;
            rsp.entry_count  <= COUNT_FIELD_W'(count);
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(STACK_DEPTH))
    else $error("entry count above capacity");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    req_fire |=> (state != S_IDLE))
    else $error("sequencer idle after accepting a beat");

  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == ST_EMPTY) |->
      (rsp.popped_value == MINUS_ONE && rsp.entry_count == '0))
    else $error("empty pop response malformed");

  a_sort_occupancy: assert property (@(posedge clk) disable iff (rst)
    (state == S_SRT_POP || state == S_SRT_CMP || state == S_POUR) |->
      (({1'b0, count} + {1'b0, ap}) <= (CNT_W + 1)'(STACK_DEPTH)))
    else $error("sort holds more words than capacity");

  a_remove_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_RM_CHK) |-> (ap < idx))
    else $error("remove write index overtook read index");

endmodule
